[rtl/core/mpo_pkg.sv]
// ----------------------------------------------------------------------------
// mpo_pkg
// Shared constants, state encoding and the quarter-wave sine table for the
// morphing polyBLEP oscillator.
// ----------------------------------------------------------------------------
package mpo_pkg;

    // Phase accumulator and the Q0.32 view of the phase
    localparam int PHASE_BITS = 32;
    localparam int T_BITS     = 32;

    // Sine table: full-cycle size, stored as one quarter plus its end point
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int SINE_IDX_BITS      = $clog2(SINE_TABLE_ENTRIES);
    localparam int SINE_QTR           = SINE_TABLE_ENTRIES / 4;
    localparam int SINE_J_BITS        = SINE_IDX_BITS - 1;
    localparam int SINE_W             = 31;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30_U   = 64'd1073741824;

    // Duty clamp (Q0.16) and morph limit (Q2.14)
    localparam logic [15:0] DUTY_MIN  = 16'd3277;
    localparam logic [15:0] DUTY_MAX  = 16'd62259;
    localparam logic [15:0] MORPH_MAX = 16'd49152;
    localparam logic [15:0] MORPH_RST = 16'd32768;
    localparam int          FRAC_BITS = 14;

    // Request kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_RESET  = 1'b1;

    // Divider: quotient bits, two bits retired per cycle
    localparam int QUO_BITS     = 30;
    localparam int DIV_STEPS    = QUO_BITS / 2;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Datapath widths
    localparam int SHAPE_W = 33;
    localparam int DIFF_W  = 34;
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 31;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int V_W     = 36;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SINE,
        ST_BLEP_SETUP,
        ST_DIV,
        ST_SQUARE,
        ST_BLEP_FIN,
        ST_SHAPE,
        ST_SELECT,
        ST_MULT,
        ST_ROUND,
        ST_DONE
    } mpo_state_t;

    typedef logic [SINE_QTR:0][SINE_W-1:0] sine_tab_t;

    // Sine of a quarter-wave point j (0..SINE_QTR), Q1.30, Taylor series by Horner
    function automatic logic [SINE_W-1:0] sine_q30(input int unsigned j);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        r    = longint'(j) << (32 - SINE_IDX_BITS);
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = ONE_Q30_U;
        term = ONE_Q30_U - ((x2 * term) >> 30) / 156;
        term = ONE_Q30_U - ((x2 * term) >> 30) / 110;
        term = ONE_Q30_U - ((x2 * term) >> 30) / 72;
        term = ONE_Q30_U - ((x2 * term) >> 30) / 42;
        term = ONE_Q30_U - ((x2 * term) >> 30) / 20;
        term = ONE_Q30_U - ((x2 * term) >> 30) / 6;
        s    = (x * term) >> 30;
        return s[SINE_W-1:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int j = 0; j <= SINE_QTR; j++) begin
            tab[j] = sine_q30(j);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[rtl/core/morphing_polyblep_oscillator.sv]
// ----------------------------------------------------------------------------
// morphing_polyblep_oscillator
// Phase-accumulator oscillator: sine, triangle, polyBLEP saw and square,
// blended by a morph position, one sample per request.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                     Direction
//  -------   ---------------------------------------   ---------
//  input     s_valid/s_ready, s_kind, s_phase_increment,
//            s_pulse_width                             in
//  result    m_valid/m_ready, m_sample                 out
//  config    cfg_valid/cfg_ready, cfg_data (morph)     in
//
//  A sample request steps through sine, polyBLEP setup, shape, select,
//  multiply and round; each polyBLEP correction that applies adds a pass
//  through the two-bit-per-cycle divider; a reset request skips to output.
//  One request is in flight at a time; the finished sample waits in the
//  output register while the next request is taken.
//  Synchronous active-low reset clears the phase to zero and the morph
//  position to 2.0 (saw). cfg_ready is always high.
//
module morphing_polyblep_oscillator
    import mpo_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [31:0]         s_phase_increment,
    input  logic [15:0]         s_pulse_width,

    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_sample,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    localparam logic signed [SHAPE_W-1:0] ONE_S = SHAPE_W'(ONE_Q30_U);
    localparam logic [32:0]               WRAP  = 33'h1_0000_0000;
    localparam logic [31:0]               HALF  = 32'h8000_0000;

    mpo_state_t state_reg, state_next;

    logic [PHASE_BITS-1:0]          phase_reg;
    logic [15:0]                    morph_reg;
    logic [T_BITS-1:0]              t_reg;
    logic [31:0]                    dt_reg;
    logic [31:0]                    w_reg;
    logic                           bsel_reg;
    logic [31:0]                    rem_reg;
    logic [QUO_BITS-1:0]            q_reg;
    logic [DIV_CNT_BITS-1:0]        cnt_reg;
    logic                           tail_reg;
    logic signed [31:0]             blep_reg [2];
    logic signed [SHAPE_W-1:0]      sine_reg, tri_reg, saw_reg, sqr_reg;
    logic signed [SHAPE_W-1:0]      base_reg;
    logic signed [DIFF_W-1:0]       diff_reg;
    logic [FRAC_BITS-1:0]           frac_reg;
    logic signed [PROD_W-1:0]       mul_reg;
    logic signed [15:0]             res_reg;
    logic                           m_valid_reg;
    logic signed [15:0]             m_sample_reg;

    logic                           accept;
    logic                           load_out;

    // Phase conversion between accumulator width and Q0.32
    logic [PHASE_BITS+31:0]         t_wide, inc_wide;
    logic [15:0]                    duty;

    assign t_wide   = {phase_reg, 32'b0} >> PHASE_BITS;
    assign inc_wide = {s_phase_increment, {PHASE_BITS{1'b0}}} >> 32;

    always_comb begin
        duty = s_pulse_width;
        if (duty < DUTY_MIN) duty = DUTY_MIN;
        if (duty > DUTY_MAX) duty = DUTY_MAX;
    end

    // polyBLEP case test on the current edge phase
    logic [31:0] t_cur;
    logic [32:0] t_sum;
    logic        lt_dt, past_end, need_blep;

    assign t_cur     = bsel_reg ? (t_reg - w_reg) : t_reg;
    assign t_sum     = {1'b0, t_cur} + {1'b0, dt_reg};
    assign lt_dt     = t_cur < dt_reg;
    assign past_end  = t_sum > WRAP;
    assign need_blep = lt_dt | past_end;

    // Divider: retire two quotient bits per cycle
    logic [32:0] r1, r2;
    logic        ge1, ge2;
    logic [31:0] r1s, rem_step;

    always_comb begin
        r1       = {rem_reg, 1'b0};
        ge1      = r1 >= {1'b0, dt_reg};
        r1s      = ge1 ? 32'(r1 - {1'b0, dt_reg}) : r1[31:0];
        r2       = {r1s, 1'b0};
        ge2      = r2 >= {1'b0, dt_reg};
        rem_step = ge2 ? 32'(r2 - {1'b0, dt_reg}) : r2[31:0];
    end

    // Finish one polyBLEP term from the quotient and its square
    logic signed [SHAPE_W-1:0] twice_q, q_sq, blep_val;

    assign twice_q  = $signed({2'b00, q_reg, 1'b0});
    assign q_sq     = $signed({3'b000, mul_reg[2*QUO_BITS-1:QUO_BITS]});
    assign blep_val = tail_reg ? (q_sq - twice_q + ONE_S) : (twice_q - q_sq - ONE_S);

    // Sine lookup: fold into one quarter, sign from the half
    logic [SINE_IDX_BITS-1:0] sidx;
    logic [SINE_J_BITS-1:0]   sj;
    logic [SINE_W-1:0]        stab;
    logic signed [SHAPE_W-1:0] sine_mag;

    always_comb begin
        sidx = t_reg[T_BITS-1 -: SINE_IDX_BITS];
        if (sidx[SINE_IDX_BITS-2]) begin
            sj = SINE_J_BITS'(SINE_QTR) - {1'b0, sidx[SINE_IDX_BITS-3:0]};
        end else begin
            sj = {1'b0, sidx[SINE_IDX_BITS-3:0]};
        end
        stab     = SINE_TAB[sj];
        sine_mag = $signed({2'b00, stab});
    end

    // Remaining shapes
    logic [31:0]               tri_mag;
    logic signed [SHAPE_W-1:0] blep0_s, blep1_s, tri_val, saw_val, sqr_val;

    always_comb begin
        tri_mag = t_reg[31] ? (t_reg - HALF) : (HALF - t_reg);
        blep0_s = SHAPE_W'(blep_reg[0]);
        blep1_s = SHAPE_W'(blep_reg[1]);
        tri_val = $signed({1'b0, tri_mag}) - ONE_S;
        saw_val = $signed({2'b00, t_reg[31:1]}) - ONE_S - blep0_s;
        sqr_val = ((t_reg < w_reg) ? ONE_S : -ONE_S) + blep0_s - blep1_s;
    end

    // Blend selection
    logic [15:0]               pos;
    logic [1:0]                k_lo, k_hi;
    logic signed [SHAPE_W-1:0] shape_lo, shape_hi;

    always_comb begin
        pos  = (morph_reg > MORPH_MAX) ? MORPH_MAX : morph_reg;
        k_lo = pos[15:14];
        k_hi = (k_lo == 2'd3) ? 2'd3 : 2'(k_lo + 2'd1);
        case (k_lo)
            2'd0:    shape_lo = sine_reg;
            2'd1:    shape_lo = tri_reg;
            2'd2:    shape_lo = saw_reg;
            default: shape_lo = sqr_reg;
        endcase
        case (k_hi)
            2'd0:    shape_hi = sine_reg;
            2'd1:    shape_hi = tri_reg;
            2'd2:    shape_hi = saw_reg;
            default: shape_hi = sqr_reg;
        endcase
    end

    // Shared multiplier operands: quotient square, then blend weight
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQUARE: begin
                mul_a = $signed({{(MUL_A_W-QUO_BITS){1'b0}}, q_reg});
                mul_b = $signed({{(MUL_B_W-QUO_BITS){1'b0}}, q_reg});
            end
            ST_MULT: begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = $signed({{(MUL_B_W-FRAC_BITS){1'b0}}, frac_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round and saturate the blend
    logic signed [PROD_W-1:0] scaled_w;
    logic signed [V_W-1:0]    v_sum, v_rnd, v_shift;
    logic signed [15:0]       v_sat;

    always_comb begin
        scaled_w = mul_reg >>> FRAC_BITS;
        v_sum    = V_W'(base_reg) + scaled_w[V_W-1:0];
        v_rnd    = v_sum + V_W'(32768);
        v_shift  = v_rnd >>> 16;
        if (v_shift > V_W'(32767)) begin
            v_sat = 16'sh7fff;
        end else if (v_shift < -V_W'(32768)) begin
            v_sat = -16'sh8000;
        end else begin
            v_sat = v_shift[15:0];
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state and handshake controls
    always_comb begin
        state_next = state_reg;
        accept     = 1'b0;
        load_out   = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    accept     = 1'b1;
                    state_next = (s_kind == KIND_RESET) ? ST_DONE : ST_SINE;
                end
            end
            ST_SINE: begin
                state_next = ST_BLEP_SETUP;
            end
            ST_BLEP_SETUP: begin
                if (need_blep) begin
                    state_next = ST_DIV;
                end else if (bsel_reg) begin
                    state_next = ST_SHAPE;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                state_next = ST_BLEP_FIN;
            end
            ST_BLEP_FIN: begin
                state_next = bsel_reg ? ST_SHAPE : ST_BLEP_SETUP;
            end
            ST_SHAPE: begin
                state_next = ST_SELECT;
            end
            ST_SELECT: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state: phase, morph register, output valid, BLEP select, divider count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            morph_reg   <= MORPH_RST;
            m_valid_reg <= 1'b0;
            bsel_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (cfg_valid) morph_reg <= cfg_data;

            // Advance the phase on acceptance, or clear it for a reset request
            if (accept) begin
                if (s_kind == KIND_RESET) begin
                    phase_reg <= '0;
                end else begin
                    phase_reg <= phase_reg + inc_wide[PHASE_BITS-1:0];
                end
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:       bsel_reg <= 1'b0;
                ST_BLEP_SETUP: begin
                    if (need_blep) begin
                        cnt_reg <= DIV_CNT_BITS'(DIV_STEPS - 1);
                    end else begin
                        bsel_reg <= 1'b1;
                    end
                end
                ST_DIV:        cnt_reg <= cnt_reg - 1'b1;
                ST_BLEP_FIN:   bsel_reg <= 1'b1;
                default:       bsel_reg <= bsel_reg;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;

        if (load_out) m_sample_reg <= res_reg;

        case (state_reg)
            ST_IDLE: begin
                t_reg   <= t_wide[T_BITS-1:0];
                dt_reg  <= s_phase_increment;
                w_reg   <= {duty, 16'b0};
                res_reg <= '0;
            end
            ST_SINE: begin
                sine_reg <= sidx[SINE_IDX_BITS-1] ? -sine_mag : sine_mag;
            end
            ST_BLEP_SETUP: begin
                // Load the numerator, or record no correction
                rem_reg  <= lt_dt ? t_cur : (32'd0 - t_cur);
                tail_reg <= ~lt_dt;
                q_reg    <= '0;
                if (!need_blep) blep_reg[bsel_reg] <= '0;
            end
            ST_DIV: begin
                rem_reg <= rem_step;
                q_reg   <= {q_reg[QUO_BITS-3:0], ge1, ge2};
            end
            ST_BLEP_FIN: begin
                blep_reg[bsel_reg] <= blep_val[31:0];
            end
            ST_SHAPE: begin
                tri_reg <= tri_val;
                saw_reg <= saw_val;
                sqr_reg <= sqr_val;
            end
            ST_SELECT: begin
                base_reg <= shape_lo;
                diff_reg <= DIFF_W'(shape_hi) - DIFF_W'(shape_lo);
                frac_reg <= pos[FRAC_BITS-1:0];
            end
            ST_ROUND: begin
                res_reg <= v_sat;
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;
    assign cfg_ready = 1'b1;

endmodule
